### rtl/hcbp_pkg.sv
// Shared types and constants of the Huffman code bit packer.
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

  localparam int unsigned ByteBits   = 8;
  localparam int unsigned ReqW       = 2;
  localparam int unsigned SymbolW    = 8;
  localparam int unsigned CodeBitsW  = 32;
  localparam int unsigned CodeLenW   = 6;
  localparam int unsigned SFieldsW   = SymbolW + CodeBitsW + CodeLenW;
  localparam int unsigned SAxisDataW = ((SFieldsW + ByteBits - 1) / ByteBits) * ByteBits;
  localparam int unsigned MAxisDataW = ByteBits;

  typedef enum logic [ReqW-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_FLUSH  = 2'd2
  } req_e;

endpackage

`default_nettype wire

### rtl/huffman_code_bit_packer_core.sv
// Huffman code bit packer: table lookup and byte packing of code streams.
`timescale 1ns / 1ps
`default_nettype none

// Requests enter on s_axis: load writes one code table entry, encode appends
// the symbol's code MSB-first to the pending partial byte, flush pads and
// emits the partial byte. A request is taken every cycle unless a request that
// makes bytes waits for the output buffer to drain.
// The code table read is registered, and the packing stage fills an output
// buffer that sends one byte per cycle on m_axis while m_axis_tready is high,
// so the first byte of a request reaches m_axis once the table read register
// and then the output buffer are loaded. An encode yields up to
// (MAX_CODE_LEN + 7) / 8 bytes, four at the default length, and the byte-wide
// output port sets the rate: a request that makes bytes waits until the output
// buffer is free. m_axis_tlast marks the last byte of each request.
// The code table has no reset; encode only symbols whose entry was loaded.
module huffman_code_bit_packer_core #(
  parameter int unsigned MAX_CODE_LEN = 32,
  parameter int unsigned SYMBOL_COUNT = 256
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // symbol[7:0], code_bits[39:8], code_length[45:40], zero[47:46]
  input  wire logic [hcbp_pkg::SAxisDataW-1:0] s_axis_tdata,
  // req_type[1:0]
  input  wire logic [hcbp_pkg::ReqW-1:0]       s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // out_byte[7:0]
  output logic      [hcbp_pkg::MAxisDataW-1:0] m_axis_tdata,
  // last_byte
  output logic                                 m_axis_tlast
);
  import hcbp_pkg::*;

  localparam int unsigned AddrW  = $clog2(SYMBOL_COUNT);
  localparam int unsigned LenW   = $clog2(MAX_CODE_LEN + 1);
  localparam int unsigned MaxOut = (MAX_CODE_LEN + 7) / 8;
  localparam int unsigned CntW   = $clog2(MaxOut + 1);
  localparam int unsigned TotW   = $clog2(MAX_CODE_LEN + 8);
  localparam int unsigned WordW  = (MaxOut + 1) * ByteBits;
  localparam int unsigned BufW   = MaxOut * ByteBits;

  logic                    s_accept;
  logic [SymbolW-1:0]      in_symbol;
  logic [CodeBitsW-1:0]    in_code_bits;
  logic [CodeLenW-1:0]     in_code_length;
  req_e                    in_req;
  logic                    in_hit;

  logic                    s1_valid_q;
  req_e                    s1_req_q;
  logic                    s1_hit_q;
  logic [MAX_CODE_LEN-1:0] s1_code;
  logic [LenW-1:0]         s1_len;
  logic                    s1_adv;

  logic [ByteBits-1:0]     pend_q, pend_d;
  logic [2:0]              pend_cnt_q, pend_cnt_d;

  logic [TotW-1:0]         total;
  logic [WordW-1:0]        code_ext;
  logic [WordW-1:0]        word;
  logic [WordW-1:0]        word_sh;
  logic [CntW-1:0]         n_d;
  logic [BufW-1:0]         load_data;

  logic [BufW-1:0]         obuf_q;
  logic [CntW-1:0]         obuf_cnt_q;
  logic                    buf_free;
  logic                    m_accept;

  assign in_symbol      = s_axis_tdata[SymbolW-1:0];
  assign in_code_bits   = s_axis_tdata[SymbolW +: CodeBitsW];
  assign in_code_length = s_axis_tdata[SymbolW + CodeBitsW +: CodeLenW];
  assign in_req         = req_e'(s_axis_tuser);
  assign in_hit         = {1'b0, in_symbol} < (SymbolW + 1)'(SYMBOL_COUNT);

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign m_accept = m_axis_tvalid && m_axis_tready;

  hcbp_code_table #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_table (
    .clk_i         (clk_i),
    .wr_en_i       (s_accept && (in_req == REQ_LOAD) && in_hit),
    .wr_addr_i     (in_symbol[AddrW-1:0]),
    .code_bits_i   (in_code_bits),
    .code_length_i (in_code_length),
    .rd_en_i       (s_accept),
    .rd_addr_i     (in_symbol[AddrW-1:0]),
    .rd_code_o     (s1_code),
    .rd_len_o      (s1_len)
  );

  // pending bits sit at the top of the word, the code follows right after them
  always_comb begin
    total    = TotW'(pend_cnt_q) + TotW'(s1_len);
    code_ext = {s1_code, {(WordW - MAX_CODE_LEN){1'b0}}};
    word     = {pend_q, {(WordW - ByteBits){1'b0}}} | (code_ext >> pend_cnt_q);
    n_d        = '0;
    pend_d     = pend_q;
    pend_cnt_d = pend_cnt_q;
    load_data  = word[WordW-1 -: BufW];
    word_sh    = '0;
    unique case (s1_req_q)
      REQ_ENCODE: begin
        if (s1_hit_q) begin
          n_d        = CntW'(total >> 3);
          word_sh    = word << {n_d, 3'b000};
          pend_d     = word_sh[WordW-1 -: ByteBits];
          pend_cnt_d = total[2:0];
        end
      end
      REQ_FLUSH: begin
        if (pend_cnt_q != 3'd0) begin
          n_d = CntW'(1);
        end
        load_data  = {pend_q, {(BufW - ByteBits){1'b0}}};
        pend_d     = '0;
        pend_cnt_d = '0;
      end
      default: ;
    endcase
  end

  assign buf_free      = (obuf_cnt_q == '0) || ((obuf_cnt_q == CntW'(1)) && m_axis_tready);
  assign s1_adv        = s1_valid_q && ((n_d == '0) || buf_free);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      pend_q     <= '0;
      pend_cnt_q <= '0;
      obuf_cnt_q <= '0;
    end else begin
      if (s_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        pend_q     <= pend_d;
        pend_cnt_q <= pend_cnt_d;
      end
      if (s1_adv && (n_d != '0)) begin
        obuf_cnt_q <= n_d;
      end else if (m_accept) begin
        obuf_cnt_q <= obuf_cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_req_q <= in_req;
      s1_hit_q <= in_hit;
    end
    if (s1_adv && (n_d != '0)) begin
      obuf_q <= load_data;
    end else if (m_accept) begin
      obuf_q <= obuf_q << ByteBits;
    end
  end

  assign m_axis_tvalid = (obuf_cnt_q != '0);
  assign m_axis_tdata  = obuf_q[BufW-1 -: ByteBits];
  assign m_axis_tlast  = (obuf_cnt_q == CntW'(1));

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_accept && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("byte run broken before its last byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ByteBits'(pend_q << pend_cnt_q) == '0))
    else $error("pending byte holds bits beyond its count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_valid_q && !buf_free))
    else $error("input stalled without a blocked request");

endmodule

`default_nettype wire

### rtl/hcbp_code_table.sv
// Code table memory: saturates and left-aligns codes on write, registered read.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_code_table #(
  parameter int unsigned MAX_CODE_LEN = 32,
  parameter int unsigned SYMBOL_COUNT = 256,
  localparam int unsigned AddrW = $clog2(SYMBOL_COUNT),
  localparam int unsigned LenW  = $clog2(MAX_CODE_LEN + 1)
) (
  input  wire logic                           clk_i,
  input  wire logic                           wr_en_i,
  input  wire logic [AddrW-1:0]               wr_addr_i,
  input  wire logic [hcbp_pkg::CodeBitsW-1:0] code_bits_i,
  input  wire logic [hcbp_pkg::CodeLenW-1:0]  code_length_i,
  input  wire logic                           rd_en_i,
  input  wire logic [AddrW-1:0]               rd_addr_i,
  output logic      [MAX_CODE_LEN-1:0]        rd_code_o,
  output logic      [LenW-1:0]                rd_len_o
);
  import hcbp_pkg::*;

  localparam int unsigned EntryW = MAX_CODE_LEN + LenW;

  logic [EntryW-1:0]       mem_q [SYMBOL_COUNT];
  logic [EntryW-1:0]       rd_q;
  logic [CodeLenW-1:0]     len_sat;
  logic [CodeLenW-1:0]     shamt;
  logic [CodeBitsW-1:0]    code_shift;
  logic [MAX_CODE_LEN-1:0] code_al;

  // saturate the length, drop bits above it and place the code MSB-first
  always_comb begin
    len_sat    = (code_length_i > CodeLenW'(MAX_CODE_LEN)) ? CodeLenW'(MAX_CODE_LEN)
                                                           : code_length_i;
    shamt      = CodeLenW'(MAX_CODE_LEN) - len_sat;
    code_shift = code_bits_i << shamt;
    code_al    = code_shift[MAX_CODE_LEN-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= {len_sat[LenW-1:0], code_al};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_code_o = rd_q[MAX_CODE_LEN-1:0];
  assign rd_len_o  = rd_q[EntryW-1 -: LenW];

endmodule

`default_nettype wire

### dv/tb_huffman_code_bit_packer_core.sv
// Self-checking testbench of the Huffman code bit packer core.
`timescale 1ns / 1ps

module tb_huffman_code_bit_packer_core;
  import hcbp_pkg::*;

  localparam int unsigned MaxCodeLen = 32;
  localparam int unsigned SymbolCount = 256;
  localparam int unsigned RandomReqs = 360;
  localparam int unsigned QuietReqs = 60;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned CycleLimit = 200000;
  localparam logic [ReqW-1:0] ReqUnused = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } packed_byte_t;

  class packed_byte_predictor;
    logic [31:0]  code_mem [SymbolCount];
    logic [5:0]   len_mem  [SymbolCount];
    logic [6:0]   part_bits;
    logic [2:0]   part_cnt;
    packed_byte_t expected_bytes[$];
    int           failures;

    function new();
      part_bits = '0;
      part_cnt  = '0;
      failures  = 0;
    endfunction

    function void take_request(logic [ReqW-1:0] req, logic [7:0] sym, logic [31:0] code,
                               logic [5:0] len);
      logic [63:0]  acc;
      int           clen;
      int           total;
      int           nbytes;
      packed_byte_t b;
      if (req == REQ_LOAD) begin
        clen = (len > MaxCodeLen) ? MaxCodeLen : int'(len);
        if (clen < 32) code = code & ((32'd1 << clen) - 32'd1);
        code_mem[sym] = code;
        len_mem[sym]  = 6'(clen);
      end else if (req == REQ_ENCODE) begin
        clen = int'(len_mem[sym]);
        if (clen != 0) begin
          acc    = (64'(part_bits) << clen) | 64'(code_mem[sym]);
          total  = int'(part_cnt) + clen;
          nbytes = total / 8;
          if (nbytes > 4) nbytes = 4;
          for (int i = 0; i < nbytes; i++) begin
            b.data = 8'(acc >> (total - 8 * (i + 1)));
            b.last = (i == nbytes - 1);
            expected_bytes.push_back(b);
          end
          total     = total - 8 * nbytes;
          part_bits = 7'(acc & ((64'd1 << total) - 64'd1));
          part_cnt  = 3'(total);
        end
      end else if (req == REQ_FLUSH) begin
        if (part_cnt != 0) begin
          b.data = {1'b0, part_bits} << (8 - part_cnt);
          b.last = 1'b1;
          expected_bytes.push_back(b);
          part_bits = '0;
          part_cnt  = '0;
        end
      end
    endfunction

    function void check_byte(logic [7:0] data, logic last);
      packed_byte_t b;
      if (expected_bytes.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected byte: data %02h last %0b", data, last);
      end else begin
        b = expected_bytes.pop_front();
        if (data !== b.data || last !== b.last) begin
          failures++;
          if (failures <= 10) begin
            $display("byte mismatch: expected data %02h last %0b, got data %02h last %0b",
                     b.data, b.last, data, last);
          end
        end
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [SAxisDataW-1:0] s_axis_tdata;
  logic [ReqW-1:0]       s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [MAxisDataW-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  packed_byte_predictor predictor;
  logic [7:0]           loaded_syms[$];
  bit                   is_loaded[SymbolCount];
  bit                   sender_quiet;
  bit                   receiver_quiet;
  int unsigned          cycle_cnt;

  huffman_code_bit_packer_core #(
    .MAX_CODE_LEN(MaxCodeLen),
    .SYMBOL_COUNT(SymbolCount)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) predictor.check_byte(m_axis_tdata, m_axis_tlast);
  end

  initial begin
    int  burst;
    bit  stalled;
    m_axis_tready = 1'b0;
    @(negedge clk_i);
    forever begin
      if (receiver_quiet) begin
        m_axis_tready <= 1'b1;
        @(negedge clk_i);
      end else begin
        burst   = $urandom_range(1, 8);
        stalled = ($urandom_range(0, 2) == 0);
        repeat (burst) begin
          m_axis_tready <= !stalled;
          @(negedge clk_i);
        end
      end
    end
  end

  task automatic send_request(input logic [ReqW-1:0] req, input logic [7:0] sym,
                              input logic [31:0] code, input logic [5:0] len);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {2'b00, len, code, sym};
    do @(posedge clk_i); while (!s_axis_tready);
    predictor.take_request(req, sym, code, len);
    if (req == REQ_LOAD && !is_loaded[sym]) begin
      is_loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
    @(negedge clk_i);
  endtask

  task automatic sender_gap(input int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  initial begin
    int         kind;
    logic [7:0] sym;
    logic [5:0] len;
    predictor      = new();
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_request(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
    send_request(ReqUnused, 8'hFF, 32'hFFFF_FFFF, 6'd63);
    send_request(REQ_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32);
    send_request(REQ_LOAD, 8'hFF, 32'h0000_0000, 6'd1);
    send_request(REQ_LOAD, 8'h55, 32'hFFFF_FFFF, 6'd3);
    send_request(REQ_LOAD, 8'hAA, 32'hDEAD_BEEF, 6'd63);
    send_request(REQ_LOAD, 8'h01, 32'h1234_5678, 6'd33);
    send_request(REQ_LOAD, 8'h80, 32'hFFFF_FFFF, 6'd0);
    send_request(REQ_LOAD, 8'h7F, 32'h0000_00A5, 6'd8);
    send_request(REQ_LOAD, 8'h02, 32'h0000_007F, 6'd7);
    send_request(REQ_ENCODE, 8'h55, 32'h0, 6'd0);
    send_request(REQ_ENCODE, 8'h00, 32'h0, 6'd0);
    send_request(REQ_ENCODE, 8'h80, 32'h0, 6'd0);
    send_request(REQ_ENCODE, 8'h02, 32'h0, 6'd0);
    send_request(REQ_ENCODE, 8'h00, 32'h0, 6'd0);
    send_request(REQ_ENCODE, 8'hAA, 32'h0, 6'd0);
    send_request(REQ_ENCODE, 8'h7F, 32'h0, 6'd0);
    send_request(REQ_ENCODE, 8'hFF, 32'h0, 6'd0);
    send_request(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
    send_request(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
    send_request(REQ_ENCODE, 8'h01, 32'h0, 6'd0);
    send_request(ReqUnused, 8'h00, 32'h0, 6'd0);
    send_request(REQ_FLUSH, 8'h00, 32'h0, 6'd0);

    for (int i = 0; i < RandomReqs; i++) begin
      if (i == RandomReqs - QuietReqs) begin
        sender_quiet   = 1'b1;
        receiver_quiet = 1'b1;
      end
      if (i == RandomReqs / 2) begin
        sender_gap(1);
        while (predictor.expected_bytes.size() != 0) @(negedge clk_i);
      end
      kind = $urandom_range(0, 99);
      if (kind < 20 || loaded_syms.size() == 0) begin
        sym  = 8'($urandom_range(0, SymbolCount - 1));
        kind = $urandom_range(0, 9);
        if (kind == 0) len = 6'd0;
        else if (kind == 1) len = 6'($urandom_range(33, 63));
        else if (kind < 4) len = 6'($urandom_range(1, 8));
        else len = 6'($urandom_range(1, MaxCodeLen));
        send_request(REQ_LOAD, sym, $urandom, len);
      end else if (kind < 85) begin
        sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        send_request(REQ_ENCODE, sym, $urandom, 6'($urandom));
      end else if (kind < 95) begin
        send_request(REQ_FLUSH, 8'($urandom), $urandom, 6'($urandom));
      end else begin
        send_request(ReqUnused, 8'($urandom), $urandom, 6'($urandom));
      end
      if (!sender_quiet && $urandom_range(0, 2) == 0) sender_gap($urandom_range(1, 8));
    end
    send_request(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
    sender_gap(1);

    while (predictor.expected_bytes.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (predictor.expected_bytes.size() != 0) begin
      $display("%0d expected bytes never arrived", predictor.expected_bytes.size());
    end
    if (predictor.failures == 0 && predictor.expected_bytes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
